// ===== hdl/mwe_pkg.sv =====
`timescale 1ns / 1ps

package mwe_pkg;

    // Request codes carried in req_type
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_READ  = 3'd1;
    localparam logic [2:0] REQ_WRITE = 3'd2;
    localparam logic [2:0] REQ_ERASE = 3'd3;
    localparam logic [2:0] REQ_WRAL  = 3'd4;
    localparam logic [2:0] REQ_ERAL  = 3'd5;
    localparam logic [2:0] REQ_EWEN  = 3'd6;
    localparam logic [2:0] REQ_EWDS  = 3'd7;

    // Microwire opcodes that follow the start bit
    localparam logic [1:0] OPC_READ  = 2'b10;
    localparam logic [1:0] OPC_WRITE = 2'b01;
    localparam logic [1:0] OPC_ERASE = 2'b11;
    localparam logic [1:0] OPC_SPEC  = 2'b00;

    // Fixed address patterns of the special commands (top two address bits)
    localparam logic [7:0] PAT_WRAL = 8'h40;
    localparam logic [7:0] PAT_ERAL = 8'h80;
    localparam logic [7:0] PAT_EWEN = 8'hC0;
    localparam logic [7:0] PAT_EWDS = 8'h00;

    // Byte-organisation address width limits
    localparam logic [3:0] AW_MIN = 4'd7;
    localparam logic [3:0] AW_MAX = 4'd11;

    // Configuration register indexes
    localparam logic CFG_IDX_ORG = 1'b0;
    localparam logic CFG_IDX_AW  = 1'b1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [10:0] mem_address;
        logic [15:0] write_value;
        logic        miso_bit;
    } mwe_in_t;

    typedef struct packed {
        logic        chip_select;
        logic        mosi_bit;
        logic        clock_pulse;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_value;
        logic        rejected;
    } mwe_out_t;

    typedef struct packed {
        logic       word_org_x16;
        logic [3:0] byte_addr_width;
    } mwe_cfg_t;

endpackage

// ===== hdl/mwe_cmd_gen.sv =====
`timescale 1ns / 1ps

module mwe_cmd_gen #(
    parameter int COMMAND_BITS = 16
) (
    input  logic [2:0]              req_type,
    input  logic [10:0]             mem_address,
    input  mwe_pkg::mwe_cfg_t       cfg,
    output logic [COMMAND_BITS-1:0] cmd_word
);
    import mwe_pkg::*;

    logic [3:0]  aw_clamp;
    logic [3:0]  aw;
    logic [1:0]  opc;
    logic [7:0]  pattern;
    logic        is_spec;
    logic [15:0] start_opc;
    logic [15:0] addr_field;
    logic [15:0] pat_field;
    logic [15:0] word16;

    // Address width: clamp, then one bit less in word organisation
    always_comb begin
        if (cfg.byte_addr_width < AW_MIN) begin
            aw_clamp = AW_MIN;
        end else if (cfg.byte_addr_width > AW_MAX) begin
            aw_clamp = AW_MAX;
        end else begin
            aw_clamp = cfg.byte_addr_width;
        end
        aw = cfg.word_org_x16 ? aw_clamp - 4'd1 : aw_clamp;
    end

    // Opcode or fixed pattern per request
    always_comb begin
        opc     = OPC_SPEC;
        pattern = PAT_EWDS;
        is_spec = 1'b1;
        unique case (req_type)
            REQ_READ: begin
                opc = OPC_READ;  is_spec = 1'b0;
            end
            REQ_WRITE: begin
                opc = OPC_WRITE; is_spec = 1'b0;
            end
            REQ_ERASE: begin
                opc = OPC_ERASE; is_spec = 1'b0;
            end
            REQ_WRAL: pattern = PAT_WRAL;
            REQ_ERAL: pattern = PAT_ERAL;
            REQ_EWEN: pattern = PAT_EWEN;
            default:  pattern = PAT_EWDS;
        endcase
    end

    // Start bit and opcode above an aw-bit address field
    always_comb begin
        start_opc  = {13'd0, 1'b1, opc} << aw;
        addr_field = {5'd0, mem_address} & ~(16'hFFFF << aw);
        // pattern placed so its top bit lands at address bit aw-1
        pat_field  = {pattern, 8'd0} >> (5'd16 - {1'b0, aw});
        word16     = start_opc | (is_spec ? pat_field : addr_field);
        cmd_word   = word16[COMMAND_BITS-1:0];
    end

endmodule

// ===== hdl/mwe_engine.sv =====
`timescale 1ns / 1ps

module mwe_engine #(
    parameter int COMMAND_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  mwe_pkg::mwe_in_t   item,
    input  mwe_pkg::mwe_cfg_t  cfg,
    output mwe_pkg::mwe_out_t  res
);
    import mwe_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_CMD  = 3'd1;
    localparam logic [2:0] PH_DOUT = 3'd2;
    localparam logic [2:0] PH_DIN  = 3'd3;
    localparam logic [2:0] PH_GAP  = 3'd4;
    localparam logic [2:0] PH_POLL = 3'd5;

    localparam logic [4:0] CMD_LEN = 5'(COMMAND_BITS);

    logic [2:0]              phase_reg,   phase_next;
    logic [COMMAND_BITS-1:0] cmd_reg,     cmd_next;
    logic [15:0]             data_reg,    data_next;
    logic [4:0]              count_reg,   count_next;
    logic [2:0]              op_reg,      op_next;

    logic [COMMAND_BITS-1:0] new_cmd;
    logic [4:0]              data_len;
    logic [4:0]              count_inc;
    logic [15:0]             din_shift;
    logic                    phase_idle;

    mwe_cmd_gen #(
        .COMMAND_BITS (COMMAND_BITS)
    ) u_cmd_gen (
        .req_type    (item.req_type),
        .mem_address (item.mem_address),
        .cfg         (cfg),
        .cmd_word    (new_cmd)
    );

    assign data_len   = cfg.word_org_x16 ? 5'd16 : 5'd8;
    assign count_inc  = count_reg + 5'd1;
    assign din_shift  = {data_reg[14:0], item.miso_bit};
    // unused phase codes count as idle
    assign phase_idle = (phase_reg == PH_IDLE) || (phase_reg > PH_POLL);

    // One bit period or one request per beat
    always_comb begin
        phase_next = phase_idle ? PH_IDLE : phase_reg;
        cmd_next   = cmd_reg;
        data_next  = data_reg;
        count_next = count_reg;
        op_next    = op_reg;
        res        = '0;

        if (item.req_type != REQ_TICK) begin
            if (!phase_idle) begin
                res.rejected = 1'b1;
            end else begin
                op_next    = item.req_type;
                count_next = 5'd0;
                cmd_next   = new_cmd;
                if (item.req_type == REQ_READ) begin
                    data_next = 16'd0;
                end else if (cfg.word_org_x16) begin
                    data_next = item.write_value;
                end else begin
                    data_next = {8'd0, item.write_value[7:0]};
                end
                phase_next = PH_CMD;
            end
        end else begin
            unique case (phase_reg)
                PH_CMD: begin
                    res.chip_select = 1'b1;
                    res.clock_pulse = 1'b1;
                    res.mosi_bit    = cmd_reg[COMMAND_BITS-1];
                    cmd_next        = cmd_reg << 1;
                    count_next      = count_inc;
                    if (count_inc >= CMD_LEN) begin
                        count_next = 5'd0;
                        if (op_reg == REQ_READ) begin
                            phase_next = PH_DIN;
                        end else if (op_reg == REQ_WRITE || op_reg == REQ_WRAL) begin
                            phase_next = PH_DOUT;
                        end else if (op_reg == REQ_ERASE || op_reg == REQ_ERAL) begin
                            phase_next = PH_GAP;
                        end else begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                        end
                    end
                end
                PH_DOUT: begin
                    if (count_reg >= data_len) begin
                        count_next = 5'd0;
                        phase_next = PH_GAP;
                    end else begin
                        res.chip_select = 1'b1;
                        res.clock_pulse = 1'b1;
                        res.mosi_bit    = cfg.word_org_x16 ? data_reg[15] : data_reg[7];
                        data_next       = data_reg << 1;
                        count_next      = count_inc;
                        if (count_inc >= data_len) begin
                            count_next = 5'd0;
                            phase_next = PH_GAP;
                        end
                    end
                end
                PH_DIN: begin
                    if (count_reg >= data_len) begin
                        phase_next     = PH_IDLE;
                        count_next     = 5'd0;
                        res.done_res   = 1'b1;
                        res.read_value = data_reg;
                    end else begin
                        res.chip_select = 1'b1;
                        res.clock_pulse = 1'b1;
                        data_next       = din_shift;
                        count_next      = count_inc;
                        if (count_inc >= data_len) begin
                            phase_next     = PH_IDLE;
                            count_next     = 5'd0;
                            res.done_res   = 1'b1;
                            res.read_value = din_shift;
                        end
                    end
                end
                PH_GAP: begin
                    phase_next = PH_POLL;
                end
                PH_POLL: begin
                    res.chip_select = 1'b1;
                    if (item.miso_bit) begin
                        phase_next   = PH_IDLE;
                        res.done_res = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        res.busy_res = (phase_next != PH_IDLE);
    end

    // State update on each processed beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= '0;
            data_reg  <= '0;
            count_reg <= '0;
            op_reg    <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            data_reg  <= data_next;
            count_reg <= count_next;
            op_reg    <= op_next;
        end
    end

    // Completion always returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.done_res |=> phase_reg == PH_IDLE)
        else $error("done without return to idle");

    // Serial clock only with chip select
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.clock_pulse |-> res.chip_select)
        else $error("clock pulse while deselected");

    // A rejected request leaves the sequencer alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.rejected |=> phase_reg == $past(phase_reg)
                                 && count_reg == $past(count_reg))
        else $error("rejected request changed state");

    // Bit counter never runs past a full command word
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 5'd16)
        else $error("bit counter overrun");

endmodule

// ===== hdl/microwire_eeprom_master.sv =====
`timescale 1ns / 1ps

// An accepted input beat passes the input register, then the result register,
// which presents its result beat. Throughput: one item per cycle while m_ready
// does not stall the output; each tick item is one serial bit period.
// Reset: aresetn synchronous active low; sequencer idle, shifters cleared,
// word_org_x16 = 1, byte_addr_width = 9, both stages empty.
module microwire_eeprom_master #(
    parameter int COMMAND_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [3:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  mwe_pkg::mwe_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mwe_pkg::mwe_out_t  m_data
);
    import mwe_pkg::*;

    mwe_cfg_t cfg_reg;
    logic     in_valid_reg;
    mwe_in_t  in_reg;
    logic     out_valid_reg;
    mwe_out_t out_reg;
    mwe_out_t res;
    logic     advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.word_org_x16    <= 1'b1;
            cfg_reg.byte_addr_width <= 4'd9;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_IDX_ORG: cfg_reg.word_org_x16    <= cfg_wdata[0];
                CFG_IDX_AW:  cfg_reg.byte_addr_width <= cfg_wdata;
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input stage moves on when the result register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    mwe_engine #(
        .COMMAND_BITS (COMMAND_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mwe_pkg::*;

    localparam int CMD_BITS    = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BEATS = 105;
    localparam int NUM_PHASES  = 8;

    // Sequencer phases of the predictor
    typedef enum logic [2:0] {
        SEQ_IDLE, SEQ_CMD, SEQ_DOUT, SEQ_DIN, SEQ_GAP, SEQ_POLL
    } seq_phase_e;

    // Predicts one result per accepted beat and checks results in order
    class eeprom_scoreboard;
        mwe_out_t              expected_q[$];
        int                    errors;
        bit                    org_x16;
        logic [3:0]            aw_reg;
        seq_phase_e            seq;
        logic [CMD_BITS-1:0]   cmd_sr;
        logic [15:0]           data_sr;
        int                    bit_cnt;
        logic [2:0]            op;

        function new();
            errors  = 0;
            org_x16 = 1'b1;
            aw_reg  = 4'd9;
            seq     = SEQ_IDLE;
            cmd_sr  = '0;
            data_sr = '0;
            bit_cnt = 0;
            op      = REQ_TICK;
        endfunction

        function void set_reg(logic idx, logic [3:0] value);
            if (idx == CFG_IDX_ORG) begin
                org_x16 = value[0];
            end else begin
                aw_reg = value;
            end
        endfunction

        function bit busy();
            return seq != SEQ_IDLE;
        endfunction

        function bit polling();
            return seq == SEQ_POLL;
        endfunction

        // Address field width after clamping; word organisation drops one bit
        function int addr_bits();
            int w;
            w = aw_reg;
            if (w < AW_MIN) w = AW_MIN;
            if (w > AW_MAX) w = AW_MAX;
            return org_x16 ? w - 1 : w;
        endfunction

        function logic [CMD_BITS-1:0] cmd_word(logic [1:0] opc, logic [10:0] a);
            int          aw;
            logic [31:0] w;
            aw = addr_bits();
            w  = ({29'd0, 1'b1, opc} << aw) | ({21'd0, a} & ((32'd1 << aw) - 32'd1));
            return w[CMD_BITS-1:0];
        endfunction

        // Special commands: pattern aligned to the top two address bits
        function logic [CMD_BITS-1:0] fixed_word(logic [7:0] pat);
            int          aw;
            logic [31:0] p;
            aw = addr_bits();
            p  = {24'd0, pat};
            p  = (aw >= 8) ? (p << (aw - 8)) : (p >> (8 - aw));
            p  = p | (32'd4 << aw);
            return p[CMD_BITS-1:0];
        endfunction

        function void end_data_out();
            bit_cnt = 0;
            seq     = SEQ_GAP;
        endfunction

        function void note_input(mwe_in_t b);
            mwe_out_t r;
            int       len;
            r   = '0;
            len = org_x16 ? 16 : 8;
            if (b.req_type != REQ_TICK) begin
                if (seq != SEQ_IDLE) begin
                    r.rejected = 1'b1;
                end else begin
                    op      = b.req_type;
                    bit_cnt = 0;
                    data_sr = org_x16 ? b.write_value : {8'h00, b.write_value[7:0]};
                    case (b.req_type)
                        REQ_READ:  cmd_sr = cmd_word(OPC_READ, b.mem_address);
                        REQ_WRITE: cmd_sr = cmd_word(OPC_WRITE, b.mem_address);
                        REQ_ERASE: cmd_sr = cmd_word(OPC_ERASE, b.mem_address);
                        REQ_WRAL:  cmd_sr = fixed_word(PAT_WRAL);
                        REQ_ERAL:  cmd_sr = fixed_word(PAT_ERAL);
                        REQ_EWEN:  cmd_sr = fixed_word(PAT_EWEN);
                        default:   cmd_sr = fixed_word(PAT_EWDS);
                    endcase
                    if (b.req_type == REQ_READ) data_sr = '0;
                    seq = SEQ_CMD;
                end
            end else begin
                case (seq)
                    SEQ_CMD: begin
                        r.chip_select = 1'b1;
                        r.clock_pulse = 1'b1;
                        r.mosi_bit    = cmd_sr[CMD_BITS-1];
                        cmd_sr        = cmd_sr << 1;
                        bit_cnt++;
                        if (bit_cnt >= CMD_BITS) begin
                            bit_cnt = 0;
                            if (op == REQ_READ) begin
                                seq = SEQ_DIN;
                            end else if (op == REQ_WRITE || op == REQ_WRAL) begin
                                seq = SEQ_DOUT;
                            end else if (op == REQ_ERASE || op == REQ_ERAL) begin
                                seq = SEQ_GAP;
                            end else begin
                                seq        = SEQ_IDLE;
                                r.done_res = 1'b1;
                            end
                        end
                    end
                    SEQ_DOUT: begin
                        // a shorter length after a re-configuration ends the phase here
                        if (bit_cnt >= len) begin
                            end_data_out();
                        end else begin
                            r.chip_select = 1'b1;
                            r.clock_pulse = 1'b1;
                            r.mosi_bit    = data_sr[len-1];
                            data_sr       = data_sr << 1;
                            bit_cnt++;
                            if (bit_cnt >= len) end_data_out();
                        end
                    end
                    SEQ_DIN: begin
                        if (bit_cnt < len) begin
                            r.chip_select = 1'b1;
                            r.clock_pulse = 1'b1;
                            data_sr       = {data_sr[14:0], b.miso_bit};
                            bit_cnt++;
                        end
                        if (bit_cnt >= len) begin
                            seq          = SEQ_IDLE;
                            bit_cnt      = 0;
                            r.done_res   = 1'b1;
                            r.read_value = data_sr;
                        end
                    end
                    SEQ_GAP: seq = SEQ_POLL;
                    SEQ_POLL: begin
                        r.chip_select = 1'b1;
                        if (b.miso_bit) begin
                            seq        = SEQ_IDLE;
                            r.done_res = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            r.busy_res = (seq != SEQ_IDLE);
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(mwe_out_t got);
            mwe_out_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("result beat %0h with nothing expected", got));
            end else begin
                want = expected_q.pop_front();
                check_field("chip_select", got.chip_select, want.chip_select);
                check_field("mosi_bit", got.mosi_bit, want.mosi_bit);
                check_field("clock_pulse", got.clock_pulse, want.clock_pulse);
                check_field("busy_res", got.busy_res, want.busy_res);
                check_field("done_res", got.done_res, want.done_res);
                check_field("read_value", got.read_value, want.read_value);
                check_field("rejected", got.rejected, want.rejected);
            end
        endtask
    endclass

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_addr  = 1'b0;
    logic [3:0] cfg_wdata = '0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    mwe_in_t    s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    mwe_out_t   m_data;

    eeprom_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int cycle_count = 0;

    microwire_eeprom_master #(
        .COMMAND_BITS(CMD_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk) cycle_count++;
        $display("Verification failed");
        $finish;
    end

    // Result side: check each beat, stall at random or hold off on request
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_result(m_data);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic mwe_in_t make_beat(logic [2:0] req, logic [10:0] a,
                                          logic [15:0] wv, logic miso);
        mwe_in_t b;
        b.req_type    = req;
        b.mem_address = a;
        b.write_value = wv;
        b.miso_bit    = miso;
        return b;
    endfunction

    // Offer one beat, with random idle cycles first, and wait for acceptance
    task automatic send_beat(mwe_in_t b);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(b);
    endtask

    task automatic program_config(logic org, logic [3:0] aw);
        logic [2:0] junk;
        junk = 3'($urandom_range(7));
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_IDX_ORG;
        cfg_wdata <= {junk, org};
        @(posedge aclk);
        sb.set_reg(CFG_IDX_ORG, {junk, org});
        cfg_addr  <= CFG_IDX_AW;
        cfg_wdata <= aw;
        @(posedge aclk);
        sb.set_reg(CFG_IDX_AW, aw);
        cfg_we    <= 1'b0;
    endtask

    // Let every expected result arrive, then allow for the pipeline depth
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [10:0] pick_addr();
        case ($urandom_range(5))
            0:       return 11'h000;
            1:       return 11'h7FF;
            default: return 11'($urandom_range(2047));
        endcase
    endfunction

    // Mostly complete commands with random content; some noise in between
    task automatic random_beats(int n);
        int      good;
        mwe_in_t b;
        logic    miso;
        good = 0;
        while (good < n) begin
            b = make_beat(REQ_TICK, 11'($urandom_range(2047)),
                          16'($urandom_range(65535)), 1'($urandom_range(1)));
            if (!sb.busy()) begin
                if ($urandom_range(99) >= 8) begin
                    b.req_type    = 3'($urandom_range(REQ_EWDS, REQ_READ));
                    b.mem_address = pick_addr();
                    good++;
                end
            end else if ($urandom_range(99) < 5) begin
                // request while busy: must be rejected
                b.req_type = 3'($urandom_range(REQ_EWDS, REQ_READ));
            end else begin
                miso = sb.polling() ? ($urandom_range(99) < 30) : 1'($urandom_range(1));
                b.miso_bit = miso;
                good++;
            end
            send_beat(b);
        end
    endtask

    initial begin
        logic       org_tbl[NUM_PHASES];
        logic [3:0] aw_tbl[NUM_PHASES];
        org_tbl = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        aw_tbl  = '{4'd9, 4'd7, 4'd11, 4'd11, 4'd7, 4'd0, 4'd15, 4'd0};
        org_tbl[NUM_PHASES-1] = 1'($urandom_range(1));
        aw_tbl[NUM_PHASES-1]  = 4'($urandom_range(15));

        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle tick, one special command with every other request
        // arriving while busy, then its command bits
        send_beat(make_beat(REQ_TICK, 11'h7FF, 16'hFFFF, 1'b1));
        send_beat(make_beat(REQ_EWDS, 11'h7FF, 16'hFFFF, 1'b1));
        for (int r = REQ_READ; r <= REQ_EWEN; r++) begin
            send_beat(make_beat(3'(r), (r % 2) ? 11'h7FF : 11'h000,
                                (r % 2) ? 16'h0000 : 16'hFFFF, 1'(r % 2)));
        end
        for (int i = 0; i < CMD_BITS; i++) begin
            send_beat(make_beat(REQ_TICK, 11'h000, 16'h0000, 1'(i % 2)));
        end
        drain();

        // Random phases over several settings and idling patterns
        for (int p = 0; p < NUM_PHASES; p++) begin
            program_config(org_tbl[p], aw_tbl[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            if (p == 1) hold_left = 300;
            random_beats(PHASE_BEATS);
            drain();
        end

        if (sb.expected_q.size() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        end
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
